FILE: rtl/dws_pkg.sv
// Shared types and constants for the double-ended queue with search.
package dws_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   position;
  } res_t;

  // Circular slot: (base + off) mod DEPTH, with off < DEPTH.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/dws_store.sv
// Entry store: one write port, one registered read port.
module dws_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [dws_pkg::IDX_W-1:0]   wr_addr,
  input  logic [dws_pkg::DATA_W-1:0]  wr_data,
  input  logic [dws_pkg::IDX_W-1:0]   rd_addr,
  output logic [dws_pkg::DATA_W-1:0]  rd_data
);

  logic [dws_pkg::DATA_W-1:0] mem [dws_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/dws_ctrl.sv
// Sequencer: queue pointers, command decode and the search compare loop.
module dws_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dws_pkg::OP_W-1:0]    in_op,
  input  logic [dws_pkg::DATA_W-1:0]  in_value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output dws_pkg::res_t               res,
  output logic                        wr_en,
  output logic [dws_pkg::IDX_W-1:0]   wr_addr,
  output logic [dws_pkg::DATA_W-1:0]  wr_data,
  output logic [dws_pkg::IDX_W-1:0]   rd_addr,
  input  logic [dws_pkg::DATA_W-1:0]  rd_data
);

  localparam int IDX_W = dws_pkg::IDX_W;
  localparam int CNT_W = dws_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  dws_pkg::op_t              op_r, op_nxt;
  logic [dws_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          scan_r, scan_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  dws_pkg::res_t             res_r, res_nxt;

  logic full, empty, hit;

  assign full  = (count_r == CNT_W'(dws_pkg::DEPTH));
  assign empty = (count_r == '0);
  // the one shared comparator: stored entry against the search key
  assign hit   = (rd_data == val_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign wr_data   = val_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = front_r;
    rd_addr     = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = dws_pkg::op_t'(in_op);
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt.status   = dws_pkg::ST_OK;
        res_nxt.value    = '0;
        res_nxt.position = '0;
        state_nxt        = S_DONE;
        unique case (op_r)
          dws_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              res_nxt.status = dws_pkg::ST_FULL;
            end else begin
              front_nxt = (front_r == '0) ? IDX_W'(dws_pkg::DEPTH - 1)
                                          : front_r - IDX_W'(1);
              wr_en     = 1'b1;
              wr_addr   = front_nxt;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          dws_pkg::OP_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = dws_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = dws_pkg::slot(front_r, count_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end
          dws_pkg::OP_POP_FRONT: begin
            if (empty) begin
              res_nxt.status = dws_pkg::ST_EMPTY;
            end else begin
              rd_addr   = front_r;
              front_nxt = dws_pkg::slot(front_r, CNT_W'(1));
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_POP_WAIT;
            end
          end
          dws_pkg::OP_POP_BACK: begin
            if (empty) begin
              res_nxt.status = dws_pkg::ST_EMPTY;
            end else begin
              rd_addr   = dws_pkg::slot(front_r, count_r - CNT_W'(1));
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_POP_WAIT;
            end
          end
          dws_pkg::OP_SEARCH: begin
            if (empty) begin
              res_nxt.status = dws_pkg::ST_EMPTY;
            end else begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      S_POP_WAIT: begin
        res_nxt.value = rd_data;
        state_nxt     = S_DONE;
      end

      // issue one read per cycle; compare the previous read's data
      S_SCAN: begin
        rd_addr = dws_pkg::slot(front_r, scan_r);
        if (scan_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
          scan_nxt    = scan_r + CNT_W'(1);
        end
        if (cmp_vld_r && hit) begin
          res_nxt.status   = dws_pkg::ST_OK;
          res_nxt.position = dws_pkg::POS_W'(cmp_idx_r + CNT_W'(1));
          cmp_vld_nxt      = 1'b0;
          state_nxt        = S_DONE;
        end else if (cmp_vld_r && (cmp_idx_r == count_r - CNT_W'(1))) begin
          res_nxt.status = dws_pkg::ST_NOT_FOUND;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      op_r      <= op_nxt;
      val_r     <= val_nxt;
      scan_r    <= scan_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      res_r     <= res_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(dws_pkg::DEPTH))
    else $error("item count exceeds depth");

  a_full_push_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && full &&
     (op_r == dws_pkg::OP_PUSH_FRONT || op_r == dws_pkg::OP_PUSH_BACK))
    |=> $stable(count_r) && $stable(front_r))
    else $error("push into full queue changed pointers");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_vld_r) |-> (cmp_idx_r < count_r))
    else $error("search compared past the last entry");

  a_no_write_outside_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC))
    else $error("store written outside command execution");

endmodule

FILE: rtl/deque_with_search_core.sv
// Top level: bounded double-ended queue with linear search.
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_op, in_value
//   out     | output    | out_valid, out_ready, out_status, out_value, out_position
//
// Push, undefined op, and pop or search on an empty queue: S_EXEC, then S_DONE hands
// the result over. Pop passes S_POP_WAIT in between (one registered store read).
// Search: one stored entry compared per cycle on a single store read port;
// a hit stops the scan early, a miss compares every stored entry, DEPTH at most.
// One transaction in flight; in_ready is low from accept until the result enters
// the output register, which then holds it until out_ready.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
module deque_with_search_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dws_pkg::OP_W-1:0]          in_op,
  input  logic signed [dws_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [dws_pkg::DATA_W-1:0] out_value,
  output logic [dws_pkg::POS_W-1:0]         out_position
);

  logic                        res_valid, res_ready;
  dws_pkg::res_t               res;
  logic                        wr_en;
  logic [dws_pkg::IDX_W-1:0]   wr_addr, rd_addr;
  logic [dws_pkg::DATA_W-1:0]  wr_data, rd_data;

  logic                        out_valid_r, out_valid_nxt;
  dws_pkg::res_t               out_r, out_nxt;

  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  dws_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes a new result once the held one is gone
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_value    = out_r.value;
  assign out_position = out_r.position;

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("result handed over but output register empty");

endmodule

FILE: dv/tb_deque_with_search_core.sv
// Testbench for deque_with_search_core: random and directed commands, checked against a predictor.
`timescale 1ns / 100ps

module tb_deque_with_search_core;

  localparam int DEPTH  = dws_pkg::DEPTH;
  localparam int IDX_W  = dws_pkg::IDX_W;
  localparam int CNT_W  = dws_pkg::CNT_W;
  localparam int DATA_W = dws_pkg::DATA_W;
  localparam int OP_W   = dws_pkg::OP_W;
  localparam int POS_W  = dws_pkg::POS_W;

  localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 16;
  localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    bit                settle;   // wait for all results before sending this one
  } deque_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0] out_position;

  deque_cmd_t cmd_queue[$];
  dws_pkg::res_t awaited_results[$];
  logic [DATA_W-1:0] value_pool[POOL_SIZE];

  // predictor state
  logic [DATA_W-1:0] dq_store[DEPTH];
  logic [IDX_W-1:0]  dq_front = '0;
  logic [CNT_W-1:0]  dq_count = '0;

  int total_items = 0;
  int sent_count = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int error_count = 0;

  deque_with_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_value(out_value), .out_position(out_position)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one command to the predicted deque and returns the result it yields.
  function automatic dws_pkg::res_t deque_step(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] v);
    dws_pkg::res_t r;
    int k;
    r.status = dws_pkg::ST_OK;
    r.value = '0;
    r.position = '0;
    case (op)
      dws_pkg::OP_PUSH_FRONT, dws_pkg::OP_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = dws_pkg::ST_FULL;
        end else begin
          if (op == dws_pkg::OP_PUSH_FRONT) begin
            dq_front = IDX_W'((int'(dq_front) + DEPTH - 1) % DEPTH);
            dq_store[dq_front] = v;
          end else begin
            dq_store[IDX_W'((int'(dq_front) + int'(dq_count)) % DEPTH)] = v;
          end
          dq_count = dq_count + 1'b1;
        end
      end
      dws_pkg::OP_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = dws_pkg::ST_EMPTY;
        end else begin
          r.value = dq_store[dq_front];
          dq_front = IDX_W'((int'(dq_front) + 1) % DEPTH);
          dq_count = dq_count - 1'b1;
        end
      end
      dws_pkg::OP_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = dws_pkg::ST_EMPTY;
        end else begin
          r.value = dq_store[IDX_W'((int'(dq_front) + int'(dq_count) - 1) % DEPTH)];
          dq_count = dq_count - 1'b1;
        end
      end
      dws_pkg::OP_SEARCH: begin
        if (dq_count == 0) begin
          r.status = dws_pkg::ST_EMPTY;
        end else begin
          r.status = dws_pkg::ST_NOT_FOUND;
          for (k = 0; k < int'(dq_count); k++) begin
            if (dq_store[IDX_W'((int'(dq_front) + k) % DEPTH)] == v) begin
              r.status = dws_pkg::ST_OK;
              r.position = POS_W'(k + 1);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly values from a small pool so searches hit and duplicates occur.
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 70) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                         input bit settle = 1'b0);
    deque_cmd_t c;
    c.op = op;
    c.value = v;
    c.settle = settle;
    cmd_queue.push_back(c);
  endtask

  // Stimulus: directed opening, then bursts biased toward filling, draining or mixing.
  initial begin
    int mode, len, roll, n;
    logic [OP_W-1:0] op;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[0] = VAL_MAX;
    value_pool[1] = VAL_MIN;

    add_cmd(dws_pkg::OP_SEARCH, '0);
    add_cmd(dws_pkg::OP_POP_FRONT, $urandom);
    add_cmd(dws_pkg::OP_POP_BACK, $urandom);
    add_cmd(OP_UNDEF_FIRST, $urandom);
    add_cmd(OP_UNDEF_FIRST + 1'b1, $urandom);
    add_cmd(OP_UNDEF_LAST, $urandom);
    add_cmd(dws_pkg::OP_PUSH_FRONT, VAL_MAX);
    add_cmd(dws_pkg::OP_PUSH_BACK, VAL_MIN);
    add_cmd(dws_pkg::OP_PUSH_FRONT, '1);
    add_cmd(dws_pkg::OP_PUSH_BACK, '0);
    add_cmd(dws_pkg::OP_SEARCH, VAL_MIN);
    add_cmd(dws_pkg::OP_SEARCH, '1);
    add_cmd(dws_pkg::OP_SEARCH, '0);
    add_cmd(dws_pkg::OP_SEARCH, 32'd12345);
    add_cmd(OP_UNDEF_LAST, '1);
    add_cmd(dws_pkg::OP_POP_BACK, '0);
    add_cmd(dws_pkg::OP_POP_FRONT, '0);
    add_cmd(dws_pkg::OP_POP_BACK, '0);
    add_cmd(dws_pkg::OP_POP_FRONT, '0);
    add_cmd(dws_pkg::OP_POP_FRONT, '0);
    add_cmd(dws_pkg::OP_SEARCH, VAL_MAX);

    n = 0;
    while (n < 1100) begin
      mode = $urandom_range(0, 9);
      len = $urandom_range(20, 90);
      for (int j = 0; j < len; j++) begin
        roll = $urandom_range(0, 99);
        if (mode == 9) begin
          op = OP_W'($urandom_range(0, 7));
          add_cmd(op, $urandom, (n % 250) == 0);
        end else begin
          if (roll < 3) begin
            op = OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
          end else if (mode < 3) begin
            op = (roll < 85) ? ($urandom_range(0, 1) ? dws_pkg::OP_PUSH_FRONT
                                                     : dws_pkg::OP_PUSH_BACK) :
                 (roll < 95) ? dws_pkg::OP_SEARCH
                             : ($urandom_range(0, 1) ? dws_pkg::OP_POP_FRONT
                                                     : dws_pkg::OP_POP_BACK);
          end else if (mode < 6) begin
            op = (roll < 80) ? ($urandom_range(0, 1) ? dws_pkg::OP_POP_FRONT
                                                     : dws_pkg::OP_POP_BACK) :
                 (roll < 95) ? dws_pkg::OP_SEARCH
                             : ($urandom_range(0, 1) ? dws_pkg::OP_PUSH_FRONT
                                                     : dws_pkg::OP_PUSH_BACK);
          end else begin
            op = (roll < 33) ? dws_pkg::OP_SEARCH
                             : OP_W'($urandom_range(dws_pkg::OP_PUSH_FRONT,
                                                    dws_pkg::OP_POP_BACK));
          end
          // searches mostly use pick_value; a quarter take a random value that likely misses
          add_cmd(op, (op == dws_pkg::OP_SEARCH && $urandom_range(0, 3) == 0) ? $urandom
                                                                             : pick_value(),
                  (n % 250) == 0);
        end
        n++;
      end
    end
    total_items = cmd_queue.size();

    do @(negedge clk); while (sent_count < total_items || results_seen < total_items);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    bit calm, busy;
    deque_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) sent_count++;
      busy = in_valid && !in_ready;
      calm = (results_seen >= 400 && results_seen < 600);
      if (!busy) begin
        if (cmd_queue.size() == 0 || (!calm && $urandom_range(0, 99) < 20) ||
            (cmd_queue[0].settle && sent_count != results_seen)) begin
          in_valid <= 1'b0;
        end else begin
          c = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_op <= c.op;
          in_value <= c.value;
        end
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back the block up.
  always @(posedge clk) begin
    int hold_left, hold_mark;
    bit calm;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_mark = -1;
    end else begin
      calm = (results_seen >= 400 && results_seen < 600);
      if (hold_left == 0 && (results_seen == 150 || results_seen == 760) &&
          hold_mark != results_seen) begin
        hold_left = HOLD_CYCLES;
        hold_mark = results_seen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Monitor: predicts on each accepted command, checks each accepted result.
  always @(posedge clk) begin
    dws_pkg::res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_value !== want.value)
            report_mismatch($sformatf("value got %h want %h", out_value, want.value));
          if (out_position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d", out_position,
                                      want.position));
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) awaited_results.push_back(deque_step(in_op, in_value));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    do @(negedge clk); while (stall_cycles < STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
